// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert a property on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert a property on the standard clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif
`endif

// File: hdl/hse_pkg.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine package
// Item types, control structs, request codes and SHA-1 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  // Input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] mac_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Sequencer to hash core
  typedef struct packed {
    logic       start;
    logic       vld;
    logic       raw;
    logic [7:0] data;
  } core_ctl_t;

  // Hash core to sequencer
  typedef struct packed {
    logic        busy;
    logic [5:0]  fill;
    logic [63:0] len;
  } core_sts_t;

  typedef logic [4:0][31:0] digest_t;

  localparam logic [1:0] REQ_KEY = 2'd0;
  localparam logic [1:0] REQ_MSG = 2'd1;
  localparam logic [1:0] REQ_FIN = 2'd2;

  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] OPAD     = 8'h5c;
  localparam logic [7:0] PAD_LEAD = 8'h80;

  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned DIGEST_BYTES = 20;
  localparam int unsigned KEY_AW       = $clog2(BLOCK_BYTES);

  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [6:0] LAST_RND  = 7'd80;

  localparam digest_t SHA_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  // Round constant for round r
  function automatic logic [31:0] round_k(logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  // Byte i of a digest, big-endian within each word
  function automatic logic [7:0] digest_byte(digest_t d, logic [4:0] i);
    logic [31:0] w;
    logic [7:0]  b;
    w = d[i[4:2]];
    case (i[1:0])
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/hse_sha_core.sv
// ----------------------------------------------------------------------------
// SHA-1 hash core
// Takes one byte a cycle while not compressing into a 16-word schedule line,
// runs 80 rounds per full block and folds the result into the chaining value.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hse_sha_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hse_pkg::core_ctl_t ctl_i,
  output hse_pkg::core_sts_t      sts_o,
  output hse_pkg::digest_t        digest_o
);

  hse_pkg::digest_t chain_q;
  logic [63:0] len_q;
  logic [5:0]  fill_q;
  logic        run_q;
  logic [6:0]  rnd_q;
  logic [23:0] acc_q;
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;

  logic        accept;
  logic [31:0] f, t, wmix, wnew;

  assign accept = ctl_i.vld && !run_q;

  // Round function
  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
    end else begin
      f = b_q ^ c_q ^ d_q;
    end
    t    = {a_q[26:0], a_q[31:27]} + f + e_q + hse_pkg::round_k(rnd_q) + w_q[0];
    wmix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wmix[30:0], wmix[31]};
  end

  // Control: counts, chaining value, round sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= hse_pkg::SHA_IV;
      len_q   <= '0;
      fill_q  <= '0;
      run_q   <= 1'b0;
      rnd_q   <= '0;
    end else if (ctl_i.start) begin
      chain_q <= hse_pkg::SHA_IV;
      len_q   <= '0;
      fill_q  <= '0;
    end else if (accept) begin
      fill_q <= fill_q + 6'd1;
      if (!ctl_i.raw) begin
        len_q <= len_q + 64'd1;
      end
      if (fill_q == 6'd63) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end
    end else if (run_q) begin
      if (rnd_q == hse_pkg::LAST_RND) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
        run_q      <= 1'b0;
      end else begin
        rnd_q <= rnd_q + 7'd1;
      end
    end
  end

  // Datapath: schedule line and working variables
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= {acc_q[15:0], ctl_i.data};
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= {acc_q, ctl_i.data};
      end
      if (fill_q == 6'd63) begin
        a_q <= chain_q[0];
        b_q <= chain_q[1];
        c_q <= chain_q[2];
        d_q <= chain_q[3];
        e_q <= chain_q[4];
      end
    end else if (run_q && (rnd_q != hse_pkg::LAST_RND)) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wnew;
    end
  end

  assign sts_o.busy = run_q;
  assign sts_o.fill = fill_q;
  assign sts_o.len  = len_q;
  assign digest_o   = chain_q;

  `ASSERT_STD(a_start_idle, ctl_i.start |-> !run_q, "hash restarted during compression")
  `ASSERT_STD(a_run_empty, run_q |-> (fill_q == 6'd0), "block buffer filling during compression")
  `ASSERT_STD(a_run_first, $rose(run_q) |-> (rnd_q == 7'd0), "compression began past round zero")
  `ASSERT_STD(a_run_end, (run_q && (rnd_q == hse_pkg::LAST_RND)) |=> !run_q, "compression overran")

endmodule

`default_nettype wire

// File: hdl/hmac_sha1_engine_core.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine
// Streams key and message bytes through a SHA-1 core and emits the MAC.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_ready_o as in_data_i (req_type,
// data_byte). Send key bytes, then message bytes, then one finish item.
// Results leave on out_valid_o/out_ready_i: five 32-bit MAC words, index
// 0..4, last_word set on the fifth, only after a finish item.
// A key byte of a short key is written to the key RAM. Each 64 absorbed
// bytes start a compression, one round a cycle in the single round unit.
// The first message byte replays the 64-byte key block. A finish pads the
// inner hash, replays the key block, absorbs the inner digest and pads
// again before the first word, and first closes a long key that is still
// open.
// in_ready_o is low while an item or a compression is in progress.
// Reset clears the key RAM valid bits, counts and phase; the hash restarts.
// A stalled receiver holds the current word; the block waits until all
// five words are taken, then returns to key loading.
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_sha1_engine_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hse_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hse_pkg::out_item_t      out_data_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_KFEED  = 4'd1;
  localparam logic [3:0] S_BYTE   = 4'd2;
  localparam logic [3:0] S_PAD    = 4'd3;
  localparam logic [3:0] S_PWAIT  = 4'd4;
  localparam logic [3:0] S_KLOAD  = 4'd5;
  localparam logic [3:0] S_ISTART = 4'd6;
  localparam logic [3:0] S_OSTART = 4'd7;
  localparam logic [3:0] S_DFEED  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  localparam logic [1:0] P_LEAD = 2'd0;
  localparam logic [1:0] P_ZERO = 2'd1;
  localparam logic [1:0] P_LEN  = 2'd2;

  localparam int unsigned AW = hse_pkg::KEY_AW;
  localparam logic [AW-1:0] KEY_LAST = AW'(hse_pkg::BLOCK_BYTES - 1);
  localparam logic [AW-1:0] DIG_LAST = AW'(hse_pkg::DIGEST_BYTES - 1);

  logic [3:0]  st_q, st_d, nxt_q, nxt_d, pnxt_q, pnxt_d;
  logic [1:0]  req_q, req_d;
  logic [7:0]  byte_q, byte_d, pad_q, pad_d;
  logic        phase_q, phase_d, hashed_q, hashed_d;
  logic [6:0]  kcnt_q, kcnt_d;
  logic [63:0] kvld_q, kvld_d;
  logic        kvld_rd_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [1:0]  pstg_q, pstg_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [63:0] bits_q, bits_d;
  logic [2:0]  wsel_q, wsel_d;
  hse_pkg::digest_t inner_q, inner_d;

  hse_pkg::core_ctl_t ctl;
  hse_pkg::core_sts_t sts;
  hse_pkg::digest_t   digest;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata, key_byte;

  hse_ram #(.Width(8), .Depth(hse_pkg::BLOCK_BYTES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  hse_sha_core u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .digest_o (digest)
  );

  // Entries never written since the last clear read as zero
  assign key_byte   = kvld_rd_q ? ram_rdata : 8'h00;
  assign in_ready_o = (st_q == S_IDLE) && !sts.busy;

  // Sequencer
  always_comb begin
    st_d      = st_q;
    nxt_d     = nxt_q;
    pnxt_d    = pnxt_q;
    req_d     = req_q;
    byte_d    = byte_q;
    pad_d     = pad_q;
    phase_d   = phase_q;
    hashed_d  = hashed_q;
    kcnt_d    = kcnt_q;
    kvld_d    = kvld_q;
    idx_d     = idx_q;
    pstg_d    = pstg_q;
    lcnt_d    = lcnt_q;
    bits_d    = bits_q;
    wsel_d    = wsel_q;
    inner_d   = inner_q;
    ctl       = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    out_valid_o = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d  = in_data_i.req_type;
          byte_d = in_data_i.data_byte;
          case (in_data_i.req_type)
            hse_pkg::REQ_KEY: begin
              if (!phase_q) begin
                if (!hashed_q && !kcnt_q[6]) begin
                  // Store a short-key byte
                  ram_we    = 1'b1;
                  ram_waddr = kcnt_q[AW-1:0];
                  ram_wdata = in_data_i.data_byte;
                  kvld_d[kcnt_q[AW-1:0]] = 1'b1;
                  kcnt_d    = kcnt_q + 7'd1;
                end else if (!hashed_q) begin
                  // Key overflows the block: start hashing it
                  ctl.start = 1'b1;
                  hashed_d  = 1'b1;
                  pad_d     = 8'h00;
                  idx_d     = '0;
                  nxt_d     = S_BYTE;
                  st_d      = S_KFEED;
                end else begin
                  st_d = S_BYTE;
                end
              end
            end
            hse_pkg::REQ_MSG, hse_pkg::REQ_FIN: begin
              if (phase_q) begin
                if (in_data_i.req_type == hse_pkg::REQ_MSG) begin
                  st_d = S_BYTE;
                end else begin
                  pnxt_d = S_OSTART;
                  st_d   = S_PAD;
                end
              end else if (hashed_q) begin
                pnxt_d = S_KLOAD;
                st_d   = S_PAD;
              end else begin
                st_d = S_ISTART;
              end
            end
            default: ;
          endcase
        end
      end

      S_KFEED: begin
        // Replay the key block through the hash
        ctl.vld  = 1'b1;
        ctl.data = key_byte ^ pad_q;
        if (!sts.busy) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == KEY_LAST) begin
            st_d = nxt_q;
          end
        end
      end

      S_BYTE: begin
        ctl.vld  = 1'b1;
        ctl.data = byte_q;
        if (!sts.busy) begin
          st_d = S_IDLE;
        end
      end

      S_PAD: begin
        ctl.raw = 1'b1;
        case (pstg_q)
          P_LEAD: begin
            bits_d   = {sts.len[60:0], 3'b000};
            ctl.vld  = 1'b1;
            ctl.data = hse_pkg::PAD_LEAD;
            if (!sts.busy) begin
              pstg_d = P_ZERO;
            end
          end
          P_ZERO: begin
            if (sts.fill == hse_pkg::LEN_POS) begin
              pstg_d = P_LEN;
            end else begin
              ctl.vld  = 1'b1;
              ctl.data = 8'h00;
            end
          end
          P_LEN: begin
            ctl.vld  = 1'b1;
            ctl.data = bits_q[63:56];
            if (!sts.busy) begin
              bits_d = {bits_q[55:0], 8'h00};
              lcnt_d = lcnt_q + 3'd1;
              if (lcnt_q == 3'd7) begin
                pstg_d = P_LEAD;
                st_d   = S_PWAIT;
              end
            end
          end
          default: pstg_d = P_LEAD;
        endcase
      end

      S_PWAIT: begin
        if (!sts.busy) begin
          st_d = pnxt_q;
        end
      end

      S_KLOAD: begin
        // Replace the key with its digest, rest zero
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = hse_pkg::digest_byte(digest, idx_q[4:0]);
        if (idx_q == '0) begin
          kvld_d = '0;
        end
        kvld_d[idx_q] = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == DIG_LAST) begin
          idx_d = '0;
          st_d  = S_ISTART;
        end
      end

      S_ISTART: begin
        ctl.start = 1'b1;
        pad_d     = hse_pkg::IPAD;
        idx_d     = '0;
        phase_d   = 1'b1;
        nxt_d     = (req_q == hse_pkg::REQ_MSG) ? S_BYTE : S_PAD;
        pnxt_d    = S_OSTART;
        st_d      = S_KFEED;
      end

      S_OSTART: begin
        inner_d   = digest;
        ctl.start = 1'b1;
        pad_d     = hse_pkg::OPAD;
        idx_d     = '0;
        nxt_d     = S_DFEED;
        st_d      = S_KFEED;
      end

      S_DFEED: begin
        ctl.vld  = 1'b1;
        ctl.data = hse_pkg::digest_byte(inner_q, idx_q[4:0]);
        if (!sts.busy) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == DIG_LAST) begin
            idx_d  = '0;
            pnxt_d = S_EMIT;
            st_d   = S_PAD;
          end
        end
      end

      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          wsel_d = wsel_q + 3'd1;
          if (wsel_q == 3'd4) begin
            // Drop the key and return to key loading
            wsel_d    = '0;
            kvld_d    = '0;
            kcnt_d    = '0;
            hashed_d  = 1'b0;
            phase_d   = 1'b0;
            ctl.start = 1'b1;
            st_d      = S_IDLE;
          end
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  assign out_data_o.mac_word   = digest[wsel_q];
  assign out_data_o.word_index = wsel_q;
  assign out_data_o.last_word  = (wsel_q == 3'd4);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      nxt_q     <= S_IDLE;
      pnxt_q    <= S_IDLE;
      phase_q   <= 1'b0;
      hashed_q  <= 1'b0;
      kcnt_q    <= '0;
      kvld_q    <= '0;
      kvld_rd_q <= 1'b0;
      idx_q     <= '0;
      pstg_q    <= P_LEAD;
      lcnt_q    <= '0;
      wsel_q    <= '0;
    end else begin
      st_q      <= st_d;
      nxt_q     <= nxt_d;
      pnxt_q    <= pnxt_d;
      phase_q   <= phase_d;
      hashed_q  <= hashed_d;
      kcnt_q    <= kcnt_d;
      kvld_q    <= kvld_d;
      kvld_rd_q <= kvld_q[idx_d];
      idx_q     <= idx_d;
      pstg_q    <= pstg_d;
      lcnt_q    <= lcnt_d;
      wsel_q    <= wsel_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    byte_q  <= byte_d;
    pad_q   <= pad_d;
    bits_q  <= bits_d;
    inner_q <= inner_d;
  end

endmodule

`default_nettype wire

// File: tb/hmac_sha1_engine_core_test.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine testbench
// Streams keys, messages and finish requests through the engine and checks
// every MAC word against an in-bench HMAC-SHA1 predictor, with random
// idle cycles on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hmac_sha1_engine_core_test;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  hse_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  hse_pkg::out_item_t out_data_o;

  hmac_sha1_engine_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [7:0]  key_bytes [64];
  int unsigned key_len;
  bit          key_long;
  bit          in_msg;
  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  logic [63:0] absorbed;

  hse_pkg::in_item_t  pending_items [$];
  hse_pkg::out_item_t mac_words_due [$];
  bit        failed = 1'b0;
  bit        in_taken = 1'b0;
  bit        out_taken = 1'b0;
  int unsigned cycles = 0;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One SHA-1 compression of blk into chain
  task automatic sha_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic sha_restart();
    chain = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
              32'hC3D2E1F0};
    absorbed = '0;
  endtask

  task automatic sha_byte(logic [7:0] v);
    blk[absorbed[5:0]] = v;
    absorbed++;
    if (absorbed[5:0] == 6'd0) sha_compress();
  endtask

  task automatic sha_close(output logic [31:0] dig [5]);
    logic [63:0] bits;
    int idx;
    bits = absorbed << 3;
    idx = int'(absorbed[5:0]);
    blk[idx] = hse_pkg::PAD_LEAD;
    idx++;
    if (idx > 56) begin
      while (idx < 64) begin
        blk[idx] = 8'h00;
        idx++;
      end
      sha_compress();
      idx = 0;
    end
    while (idx < 56) begin
      blk[idx] = 8'h00;
      idx++;
    end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    sha_compress();
    dig = chain;
  endtask

  task automatic clear_key();
    foreach (key_bytes[i]) key_bytes[i] = 8'h00;
    key_len = 0;
    key_long = 1'b0;
    in_msg = 1'b0;
    sha_restart();
  endtask

  task automatic begin_inner();
    logic [31:0] dig [5];
    if (in_msg) return;
    if (key_long) begin
      sha_close(dig);
      foreach (key_bytes[i]) key_bytes[i] = 8'h00;
      for (int i = 0; i < 20; i++) key_bytes[i] = dig[i/4][31-8*(i%4) -: 8];
    end
    sha_restart();
    for (int i = 0; i < 64; i++) sha_byte(key_bytes[i] ^ hse_pkg::IPAD);
    in_msg = 1'b1;
  endtask

  // Advance the predictor by one accepted item, queue any MAC words
  task automatic predict_mac(hse_pkg::in_item_t it);
    logic [31:0] inner [5];
    logic [31:0] mac [5];
    hse_pkg::out_item_t o;
    case (it.req_type)
      hse_pkg::REQ_KEY: begin
        if (in_msg) return;
        if (!key_long && key_len < 64) begin
          key_bytes[key_len] = it.data_byte;
          key_len++;
          return;
        end
        if (!key_long) begin
          sha_restart();
          for (int i = 0; i < 64; i++) sha_byte(key_bytes[i]);
          key_long = 1'b1;
        end
        sha_byte(it.data_byte);
      end
      hse_pkg::REQ_MSG: begin
        begin_inner();
        sha_byte(it.data_byte);
      end
      hse_pkg::REQ_FIN: begin
        begin_inner();
        sha_close(inner);
        sha_restart();
        for (int i = 0; i < 64; i++) sha_byte(key_bytes[i] ^ hse_pkg::OPAD);
        for (int i = 0; i < 20; i++) sha_byte(inner[i/4][31-8*(i%4) -: 8]);
        sha_close(mac);
        for (int i = 0; i < 5; i++) begin
          o.mac_word = mac[i];
          o.word_index = 3'(i);
          o.last_word = (i == 4);
          mac_words_due.push_back(o);
        end
        clear_key();
      end
      default: ;
    endcase
  endtask

  function automatic hse_pkg::in_item_t mk(logic [1:0] r, logic [7:0] v);
    hse_pkg::in_item_t it;
    it.req_type = r;
    it.data_byte = v;
    return it;
  endfunction

  // Drive items from the pending queue with random gaps
  int unsigned in_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap = $urandom_range(0, 4);
        if (in_gap == 0 && pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (in_gap > 0) in_gap--;
        if (in_gap == 0 && pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Random stalls on the result side
  int unsigned out_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_gap = $urandom_range(0, 4);
      end
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_taken = 1'b1;
      predict_mac(in_data_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      if (mac_words_due.size() == 0) begin
        $display("%0t: unexpected MAC word, expected none, actual %h",
                 $realtime, out_data_o);
        failed = 1'b1;
      end else begin
        hse_pkg::out_item_t want;
        want = mac_words_due.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: MAC word mismatch, expected %h/%0d/%0d actual %h/%0d/%0d",
                   $realtime, want.mac_word, want.word_index, want.last_word,
                   out_data_o.mac_word, out_data_o.word_index, out_data_o.last_word);
          failed = 1'b1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_bytes(logic [1:0] r, int n);
    for (int i = 0; i < n; i++) pending_items.push_back(mk(r, 8'($urandom)));
  endtask

  initial begin
    int total;
    clear_key();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: empty key and message, extremes, code 3, late key byte
    pending_items.push_back(mk(hse_pkg::REQ_FIN, 8'hFF));
    pending_items.push_back(mk(hse_pkg::REQ_KEY, 8'h00));
    pending_items.push_back(mk(hse_pkg::REQ_KEY, 8'hFF));
    pending_items.push_back(mk(2'd3, 8'hAA));
    pending_items.push_back(mk(hse_pkg::REQ_MSG, 8'hFF));
    pending_items.push_back(mk(hse_pkg::REQ_KEY, 8'h55));
    pending_items.push_back(mk(hse_pkg::REQ_MSG, 8'h00));
    pending_items.push_back(mk(hse_pkg::REQ_FIN, 8'h00));
    pending_items.push_back(mk(hse_pkg::REQ_MSG, 8'h5A));
    pending_items.push_back(mk(hse_pkg::REQ_FIN, 8'h00));
    // Long key of 66 bytes, message whose padding spills into an extra block
    add_bytes(hse_pkg::REQ_KEY, 66);
    add_bytes(hse_pkg::REQ_MSG, 60);
    pending_items.push_back(mk(hse_pkg::REQ_FIN, 8'h00));

    // Random MACs: mostly well-formed, some noise
    total = pending_items.size();
    while (total < 350) begin
      int nk, nm;
      nk = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 80) : $urandom_range(0, 24);
      nm = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
      add_bytes(hse_pkg::REQ_KEY, nk);
      add_bytes(hse_pkg::REQ_MSG, nm);
      if ($urandom_range(0, 3) == 0) begin
        pending_items.push_back(mk(hse_pkg::REQ_KEY, 8'($urandom)));
        pending_items.push_back(mk(2'd3, 8'($urandom)));
        total += 2;
      end
      pending_items.push_back(mk(hse_pkg::REQ_FIN, 8'($urandom)));
      total += nk + nm + 1;
    end

    wait (pending_items.size() == 0 && !in_valid_i);
    wait (mac_words_due.size() == 0);
    repeat (600) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/hse_pkg.sv
hdl/hse_ram.sv
hdl/hse_sha_core.sv
hdl/hmac_sha1_engine_core.sv
tb/hmac_sha1_engine_core_test.sv
